// ===== hdl/sha_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [31:0] word_t;

  // Front-end command passed to the compression back end.
  typedef struct packed {
    logic        is_byte;
    logic [7:0]  data;
    logic        is_end;
  } cmd_t;

  // Initial hash values.
  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Round constants.
  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha_if.sv =====
// Valid/ready stream interfaces for the input bytes and the digest words.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source(output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha_front.sv =====
// Front end: accepts input transactions, drops empty ones and queues commands.
module sha_front #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  sha_in_if.sink        in_ch,
  output sha_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_take
);
  import sha_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          q [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;

  assign in_ch.ready = (count != (AW+1)'(Depth));
  // Transactions with neither a byte nor an end mark change nothing.
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_valid || in_ch.end_of_message);
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];

  // Small circular command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(cmd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{is_byte: in_ch.byte_valid, data: in_ch.data_byte,
                     is_end: in_ch.end_of_message};
    end
  end
endmodule

// ===== hdl/sha_core.sv =====
// Back end: block assembly, padding, 64-round compression and digest output.
module sha_core (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_take,
  sha_out_if.source     out_ch,
  output logic          busy
);
  import sha_pkg::*;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  logic [6:0]  fill;
  logic [63:0] message_bits;
  logic        finishing;
  logic        final_pass;
  logic        mark_pending;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  word_t       chain [8];
  word_t       v [8];
  word_t       win [16];
  logic        take_byte;

  // Shift register of 16 words; bytes enter at the low byte of word 15 and words move toward word 0.
  word_t w_new;
  word_t w_cur;
  word_t s0;
  word_t s1;
  word_t t1;
  word_t t2;

  assign w_cur = (round < 6'd16) ? win[0] : w_new;
  assign s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
  assign s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
  assign w_new = s1 + win[9] + s0 + win[0];
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w_cur;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign cmd_take = (state == ST_LOAD) && cmd_valid;
  assign take_byte = cmd_take && cmd.is_byte;
  assign busy = (state != ST_LOAD);

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.digest_word = chain[out_idx];
  assign out_ch.word_index = out_idx;
  assign out_ch.last_word = (out_idx == 3'd7);

  // Byte shifted into the window as a big-endian word stream.
  function automatic void push_byte(inout word_t w [16], input logic [7:0] b,
                                    input logic [5:0] pos);
    word_t shifted;
    shifted = {w[15][23:0], b};
    if (pos[1:0] == 2'd0) begin
      for (int i = 0; i < 15; i++) begin
        w[i] = w[i+1];
      end
    end
    w[15] = shifted;
  endfunction

  // Control and datapath sequencing.
  always_ff @(posedge clk) begin
    word_t wtmp [16];
    logic [63:0] bits_tmp;
    if (rst) begin
      state        <= ST_LOAD;
      fill         <= '0;
      message_bits <= '0;
      finishing    <= 1'b0;
      final_pass   <= 1'b0;
      mark_pending <= 1'b0;
      round        <= '0;
      out_idx      <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= iv_word(3'(i));
      end
    end else begin
      wtmp = win;
      case (state)
        ST_LOAD: begin
          if (cmd_take) begin
            if (take_byte) begin
              push_byte(wtmp, cmd.data, fill[5:0]);
            end
            if (take_byte && fill == 7'd63) begin
              // The block is full; an end mark here still owes the 0x80 byte.
              win          <= wtmp;
              fill         <= 7'd64;
              finishing    <= cmd.is_end;
              mark_pending <= cmd.is_end;
              final_pass   <= 1'b0;
              state        <= ST_INIT;
            end else if (cmd.is_end) begin
              finishing <= 1'b1;
              bits_tmp = message_bits + {54'd0, take_byte ? fill + 7'd1 : fill, 3'd0};
              message_bits <= bits_tmp;
              state <= ST_PAD;
              push_byte(wtmp, 8'h80, fill[5:0] + {5'd0, take_byte});
              win  <= wtmp;
              fill <= take_byte ? fill + 7'd2 : fill + 7'd1;
            end else if (take_byte) begin
              win  <= wtmp;
              fill <= fill + 7'd1;
            end
          end
        end
        ST_PAD: begin
          // Write a pending 0x80 mark, then pad with zeros; the length goes into bytes 56..63 of the last block.
          if (mark_pending) begin
            push_byte(wtmp, 8'h80, fill[5:0]);
            win          <= wtmp;
            fill         <= fill + 7'd1;
            mark_pending <= 1'b0;
          end else if (fill == 7'd64) begin
            final_pass <= 1'b0;
            state      <= ST_INIT;
          end else if (fill == 7'd56) begin
            for (int i = 0; i < 14; i++) begin
              wtmp[i] = wtmp[i+2];
            end
            wtmp[14] = message_bits[63:32];
            wtmp[15] = message_bits[31:0];
            win        <= wtmp;
            final_pass <= 1'b1;
            state      <= ST_INIT;
          end else begin
            push_byte(wtmp, 8'h00, fill[5:0]);
            win  <= wtmp;
            fill <= fill + 7'd1;
          end
        end
        ST_INIT: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= chain[i];
          end
          round <= '0;
          state <= ST_RND;
        end
        ST_RND: begin
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_cur;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          fill <= '0;
          if (!finishing) begin
            message_bits <= message_bits + 64'd512;
            state <= ST_LOAD;
          end else if (final_pass) begin
            out_idx <= '0;
            state   <= ST_OUT;
          end else begin
            // A message that ended on a full block counts that block here.
            if (mark_pending) begin
              message_bits <= message_bits + 64'd512;
            end
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= iv_word(3'(i));
              end
              fill         <= '0;
              message_bits <= '0;
              finishing    <= 1'b0;
              final_pass   <= 1'b0;
              mark_pending <= 1'b0;
              state        <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end
endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// A byte that does not end a block is absorbed into the current block.
// A full block costs one compression; a message end costs padding, one or two
// compressions and the output of the eight digest words.
// Throughput is set by the single 64-round compression loop in the back end.
// Reset is synchronous and active high; it loads the initial hash values.
// Top level of the SHA-256 stream hasher.
module sha256_stream_hasher #(
  parameter int QueueDepth = 4
) (
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic busy;

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .out_ch(out_ch), .busy(busy)
  );

`ifndef ASSERT_OFF
  // Commands are only taken while the back end is idle.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !busy) else $error("command taken while busy");
  // Digest words leave only while the back end is busy.
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> busy) else $error("output without busy");
  // A stalled digest word holds its index.
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.word_index))
    else $error("word index moved under stall");
`endif
endmodule

// ===== bench/sha256_stream_hasher_tb.sv =====
// Testbench for the SHA-256 stream hasher: random byte streams checked against a local digest model.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
  import sha_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic clk;
  logic rst;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // One expected digest word.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  digest_beat_t expected_words[$];

  // Local copy of the hashing state.
  logic [31:0] hash_state [8];
  logic [7:0]  pending_bytes [64];
  int unsigned pending_count;
  logic [63:0] total_bits;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          sink_busy_ok;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Standard iv values, kept locally so the prediction is independent.
  function automatic logic [31:0] start_word(input int unsigned i);
    logic [31:0] iv [8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return iv[i];
  endfunction

  task automatic clear_hash_state();
    for (int i = 0; i < 8; i++) hash_state[i] = start_word(i);
    pending_count = 0;
    total_bits    = '0;
  endtask

  // Round constants are a standard table, taken here from the package.
  task automatic compress_pending();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {pending_bytes[4*i], pending_bytes[4*i+1], pending_bytes[4*i+2],
              pending_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  // Advance the digest model by one accepted transaction.
  task automatic predict_digest(input logic [7:0] b, input logic bv, input logic eom);
    digest_beat_t beat;
    if (bv) begin
      pending_bytes[pending_count] = b;
      pending_count++;
      if (pending_count == 64) begin
        compress_pending();
        total_bits += 64'd512;
        pending_count = 0;
      end
    end
    if (eom) begin
      total_bits += 64'(pending_count * 8);
      pending_bytes[pending_count] = 8'h80;
      pending_count++;
      if (pending_count > 56) begin
        while (pending_count < 64) pending_bytes[pending_count++] = 8'h00;
        compress_pending();
        pending_count = 0;
      end
      while (pending_count < 56) pending_bytes[pending_count++] = 8'h00;
      for (int i = 0; i < 8; i++) pending_bytes[56 + i] = total_bits[8*(7-i) +: 8];
      compress_pending();
      for (int i = 0; i < 8; i++) begin
        beat.digest_word = hash_state[i];
        beat.word_index  = i[2:0];
        beat.last_word   = (i == 7);
        expected_words.push_back(beat);
      end
      clear_hash_state();
    end
  endtask

  // Random gap: mostly short, sometimes long.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one transaction and hand it to the model once accepted.
  // Valid stays high into the next transaction when there is no gap.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
    int unsigned gap;
    gap = random_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.byte_valid     <= bv;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(b, bv, eom);
  endtask

  task automatic send_message(input int unsigned len, input bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)),
                1'b1, (end_with_byte && i == len - 1));
    if (!end_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Release the input and wait until every expected word has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Directed: empty message, extreme bytes, end with and without a byte.
  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
  endtask

  // Padding boundaries: length fits exactly, length spills into a second block, full block.
  task automatic test_padding_edges();
    send_message(55, 1'b1);
    send_message(62, 1'b1);
    send_message(64, 1'b1);
  endtask

  // Hold the source until every digest has come back, then resume.
  task automatic test_drain_pause();
    send_message(3, 1'b1);
    wait_drained();
    send_message(1, 1'b0);
  endtask

  // Random short messages, with idle noise mixed in.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 15) begin
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 1));
      sent += len + 1;
    end
  endtask

  // Sink: random back-pressure and the result checker.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      sink_busy_ok = ($urandom_range(0, 99) < 10) ? 1'b0 : ($urandom_range(0, 2) != 0);
      out_ch.ready <= sink_busy_ok;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected digest word %h index %0d", out_ch.digest_word,
                     out_ch.word_index);
        end else begin
          digest_beat_t exp_beat;
          exp_beat = expected_words.pop_front();
          if (exp_beat.digest_word !== out_ch.digest_word ||
              exp_beat.word_index !== out_ch.word_index ||
              exp_beat.last_word !== out_ch.last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       exp_beat.digest_word, exp_beat.word_index, exp_beat.last_word,
                       out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.byte_valid     = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    mismatch_count       = 0;
    idle_cycles          = 0;
    timed_out            = 1'b0;
    clear_hash_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_padding_edges();
    test_drain_pause();
    test_random_messages();

    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_front.sv
hdl/sha_core.sv
hdl/sha256_stream_hasher.sv
bench/sha256_stream_hasher_tb.sv
